/* rtl/vfcm_pkg.sv */
// ----------------------------------------------------------------------------
// vfcm_pkg: shared types and constants of the voxel face culling mesher
// Command codes, default parameters, stream widths, normals and corner table.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_CELL  = 2'd0,
        CMD_LOAD_PLANE = 2'd1,
        CMD_SET_MASK   = 2'd2,
        CMD_EXAMINE    = 2'd3
    } t_cmd;

    localparam int DEF_SIDE       = 16;
    localparam int DEF_BLOCK_BITS = 8;

    localparam int IDX_W     = 12;
    localparam int DIR_W     = 3;
    localparam int VAL_W     = 8;
    localparam int MASK_W    = 6;
    localparam int POS_W     = 5;
    localparam int NORM_W    = 8;
    localparam int NUM_DIRS  = 6;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    localparam logic signed [NORM_W-1:0] NORMAL_POS  = 8'sd127;
    localparam logic signed [NORM_W-1:0] NORMAL_NEG  = -8'sd127;
    localparam logic signed [NORM_W-1:0] NORMAL_ZERO = 8'sd0;

    // corner offsets per face, coded as x | y<<1 | z<<2
    localparam logic [2:0] CORNER_TAB [NUM_DIRS][4] = '{
        '{3'd0, 3'd4, 3'd2, 3'd6},
        '{3'd1, 3'd3, 3'd5, 3'd7},
        '{3'd0, 3'd1, 3'd4, 3'd5},
        '{3'd2, 3'd6, 3'd3, 3'd7},
        '{3'd0, 3'd2, 3'd1, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd7}
    };

endpackage

/* rtl/voxel_face_culling_mesher.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher: culled face mesher for one voxel chunk
// Stores a chunk and its six neighbor boundary planes; emits face vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the command (load cell, load plane cell, set
//   presence mask, examine face); tdata carries cell index, face direction,
//   block value and presence mask. Loads and mask writes give no output.
//   Master stream: an examine whose cell is solid and whose neighbor across
//   the face is empty gives four vertex transactions, tlast on the fourth.
//   Faces toward an absent neighbor chunk are never emitted.
// Throughput: one item per cycle through a seven-stage pipeline (input,
//   two reciprocal-multiply stages, coordinate stage, address stage,
//   memory read stage, output register), unless an emitting examine in the
//   read stage waits for the output register, which holds each face until
//   its fourth vertex is taken. Loads write the memories in the read stage, in item order.
// Reset: valid bits, the output register and the presence mask clear; the
//   chunk and plane memories keep their contents and must be loaded first.
// Stall: while tready is low on the master side the current vertex holds
//   and the pipeline fills behind it; slave tready drops once it is full.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher #(
    parameter int SIDE       = vfcm_pkg::DEF_SIDE,
    parameter int BLOCK_BITS = vfcm_pkg::DEF_BLOCK_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [11:0] cell_index, [14:12] face_dir, [22:15] block_value,
    // [28:23] present_mask, [31:29] zero
    input  logic [vfcm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [1:0] cmd
    input  logic [vfcm_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [4:0] pos_x, [9:5] pos_y, [14:10] pos_z, [22:15] normal_x,
    // [30:23] normal_y, [38:31] normal_z, [46:39] vertex_block, [47] zero
    output logic [vfcm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int IW     = vfcm_pkg::IDX_W;
    localparam int CW     = $clog2(SIDE);
    localparam int PLANE  = SIDE * SIDE;
    localparam int CELLS  = SIDE * SIDE * SIDE;
    localparam int CDEPTH = (CELLS < (1 << IW)) ? CELLS : (1 << IW);
    localparam int PDEPTH = vfcm_pkg::NUM_DIRS * PLANE;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int PAW    = $clog2(PDEPTH);
    localparam int SH     = IW + CW;
    localparam int RW     = IW + 2;
    localparam int PW     = IW + RW;
    localparam int RECIP  = ((1 << SH) + SIDE - 1) / SIDE;
    localparam int NSTG   = 5;

    typedef struct packed {
        vfcm_pkg::t_cmd             cmd;
        logic [IW-1:0]              idx;
        logic [2:0]                 dir;
        logic [7:0]                 val;
        logic [5:0]                 mask;
        logic [IW-1:0]              q1;
        logic [IW-1:0]              q2;
        logic [CW-1:0]              x;
        logic [CW-1:0]              y;
        logic [CW-1:0]              z;
        logic                       exam;
        logic                       bnd;
        logic                       wr_cell;
        logic                       wr_plane;
        logic [CAW-1:0]             adj_addr;
        logic [PAW-1:0]             pln_addr;
    } t_pipe;

    typedef struct packed {
        logic                       exam;
        logic                       bnd;
        logic [2:0]                 dir;
        logic [CW-1:0]              x;
        logic [CW-1:0]              y;
        logic [CW-1:0]              z;
    } t_rd;

    typedef struct packed {
        logic [2:0]                 dir;
        logic [CW-1:0]              x;
        logic [CW-1:0]              y;
        logic [CW-1:0]              z;
        logic [7:0]                 blk;
    } t_face;

    t_pipe                  r_pl [NSTG];
    t_pipe                  n_pl [NSTG];
    logic [NSTG-1:0]        r_vl;
    logic [NSTG-1:0]        w_en;
    t_rd                    r_rd;
    logic                   r_v5;
    logic [BLOCK_BITS-1:0]  r_rd_cell;
    logic [BLOCK_BITS-1:0]  r_rd_adj;
    logic [BLOCK_BITS-1:0]  r_rd_plane;
    logic [BLOCK_BITS-1:0]  r_chunk [CDEPTH];
    logic [BLOCK_BITS-1:0]  r_plane [PDEPTH];
    logic [5:0]             r_present;
    t_face                  r_o;
    logic                   r_ov;
    logic [1:0]             r_ok;
    logic                   w_emit5;
    logic                   w_pres;
    logic                   w_out_free;
    logic                   w_en5;
    logic [2:0]             w_cr;
    logic                   w_neg;
    logic signed [7:0]      w_nv;
    logic [4:0]             w_px;
    logic [4:0]             w_py;
    logic [4:0]             w_pz;
    logic signed [7:0]      w_nx;
    logic signed [7:0]      w_ny;
    logic signed [7:0]      w_nz;

    // stage logic
    always_comb begin
        logic [PW-1:0]  p1;
        logic [PW-1:0]  p2;
        logic [CW-1:0]  c;
        logic           neg;
        int             step;
        int             pidx;
        int             adj;

        n_pl[0]      = r_pl[0];
        n_pl[0].cmd  = vfcm_pkg::t_cmd'(i_s_tuser);
        n_pl[0].idx  = i_s_tdata[11:0];
        n_pl[0].dir  = i_s_tdata[14:12];
        n_pl[0].val  = i_s_tdata[22:15];
        n_pl[0].mask = i_s_tdata[28:23];

        n_pl[1]    = r_pl[0];
        p1         = PW'(r_pl[0].idx) * PW'(RECIP);
        n_pl[1].q1 = IW'(p1 >> SH);

        n_pl[2]    = r_pl[1];
        n_pl[2].x  = CW'(r_pl[1].idx - IW'(int'(r_pl[1].q1) * SIDE));
        p2         = PW'(r_pl[1].q1) * PW'(RECIP);
        n_pl[2].q2 = IW'(p2 >> SH);

        n_pl[3]    = r_pl[2];
        n_pl[3].y  = CW'(r_pl[2].q1 - IW'(int'(r_pl[2].q2) * SIDE));
        n_pl[3].z  = CW'(r_pl[2].q2);

        n_pl[4] = r_pl[3];
        neg     = !r_pl[3].dir[0];
        case (r_pl[3].dir[2:1])
            2'd0: begin
                c    = r_pl[3].x;
                step = 1;
                pidx = int'(r_pl[3].y) + SIDE * int'(r_pl[3].z);
            end
            2'd1: begin
                c    = r_pl[3].y;
                step = SIDE;
                pidx = int'(r_pl[3].x) + SIDE * int'(r_pl[3].z);
            end
            default: begin
                c    = r_pl[3].z;
                step = PLANE;
                pidx = int'(r_pl[3].x) + SIDE * int'(r_pl[3].y);
            end
        endcase
        adj = neg ? int'(r_pl[3].idx) - step : int'(r_pl[3].idx) + step;
        n_pl[4].bnd      = neg ? (c == '0) : (c == CW'(SIDE - 1));
        n_pl[4].exam     = (r_pl[3].cmd == vfcm_pkg::CMD_EXAMINE)
                        && (int'(r_pl[3].idx) < CELLS)
                        && (int'(r_pl[3].dir) < vfcm_pkg::NUM_DIRS);
        n_pl[4].wr_cell  = (r_pl[3].cmd == vfcm_pkg::CMD_LOAD_CELL)
                        && (int'(r_pl[3].idx) < CELLS);
        n_pl[4].wr_plane = (r_pl[3].cmd == vfcm_pkg::CMD_LOAD_PLANE)
                        && (int'(r_pl[3].idx) < PLANE)
                        && (int'(r_pl[3].dir) < vfcm_pkg::NUM_DIRS);
        n_pl[4].adj_addr = CAW'(adj);
        if (r_pl[3].cmd == vfcm_pkg::CMD_LOAD_PLANE) begin
            n_pl[4].pln_addr = PAW'(int'(r_pl[3].dir) * PLANE + int'(r_pl[3].idx));
        end else begin
            n_pl[4].pln_addr = PAW'(int'(r_pl[3].dir) * PLANE + pidx);
        end
    end

    // handshake and stage enables
    assign w_pres     = r_present[0 +: 1] == 1'b1 ? (|((r_present >> r_rd.dir) & 6'd1))
                                                  : (|((r_present >> r_rd.dir) & 6'd1));
    assign w_emit5    = r_v5 && r_rd.exam && (r_rd_cell != '0)
                     && (r_rd.bnd ? (w_pres && (r_rd_plane == '0)) : (r_rd_adj == '0));
    assign w_out_free = !r_ov || (i_m_tready && (r_ok == 2'd3));
    assign w_en5      = !r_v5 || !w_emit5 || w_out_free;

    always_comb begin
        w_en[NSTG-1] = !r_vl[NSTG-1] || w_en5;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vl[i] || w_en[i+1];
        end
    end

    assign o_s_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_vl[0] <= i_s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vl[i] <= r_vl[i-1];
                end
            end
            if (w_en5) begin
                r_v5 <= r_vl[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (w_en[i]) begin
                r_pl[i] <= n_pl[i];
            end
        end
        if (w_en5) begin
            r_rd.exam <= r_pl[4].exam;
            r_rd.bnd  <= r_pl[4].bnd;
            r_rd.dir  <= r_pl[4].dir;
            r_rd.x    <= r_pl[4].x;
            r_rd.y    <= r_pl[4].y;
            r_rd.z    <= r_pl[4].z;
        end
    end

    // chunk and plane memories
    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            if (r_vl[4] && r_pl[4].wr_cell) begin
                r_chunk[CAW'(r_pl[4].idx)] <= BLOCK_BITS'(r_pl[4].val);
            end
            if (r_vl[4] && r_pl[4].wr_plane) begin
                r_plane[r_pl[4].pln_addr] <= BLOCK_BITS'(r_pl[4].val);
            end
            r_rd_cell  <= r_chunk[CAW'(r_pl[4].idx)];
            r_rd_adj   <= r_chunk[r_pl[4].adj_addr];
            r_rd_plane <= r_plane[r_pl[4].pln_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (w_en5 && r_vl[4] && (r_pl[4].cmd == vfcm_pkg::CMD_SET_MASK)) begin
            r_present <= r_pl[4].mask;
        end
    end

    // vertex serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ok <= 2'd0;
        end else if (w_out_free) begin
            if (r_v5 && w_emit5) begin
                r_ov <= 1'b1;
                r_ok <= 2'd0;
            end else begin
                r_ov <= 1'b0;
            end
        end else if (r_ov && i_m_tready) begin
            r_ok <= r_ok + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_v5 && w_emit5) begin
            r_o.dir <= r_rd.dir;
            r_o.x   <= r_rd.x;
            r_o.y   <= r_rd.y;
            r_o.z   <= r_rd.z;
            r_o.blk <= 8'(r_rd_cell);
        end
    end

    assign w_cr  = vfcm_pkg::CORNER_TAB[r_o.dir][r_ok];
    assign w_neg = !r_o.dir[0];
    assign w_nv  = w_neg ? vfcm_pkg::NORMAL_NEG : vfcm_pkg::NORMAL_POS;
    assign w_px  = 5'(int'(r_o.x) + int'(w_cr[0]));
    assign w_py  = 5'(int'(r_o.y) + int'(w_cr[1]));
    assign w_pz  = 5'(int'(r_o.z) + int'(w_cr[2]));
    assign w_nx  = (r_o.dir[2:1] == 2'd0) ? w_nv : vfcm_pkg::NORMAL_ZERO;
    assign w_ny  = (r_o.dir[2:1] == 2'd1) ? w_nv : vfcm_pkg::NORMAL_ZERO;
    assign w_nz  = (r_o.dir[2:1] == 2'd2) ? w_nv : vfcm_pkg::NORMAL_ZERO;

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = (r_ok == 2'd3);
    assign o_m_tdata  = {1'b0, r_o.blk, w_nz, w_ny, w_nx, w_pz, w_py, w_px};

    // checks
    a_mask_write_only_by_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_present) |->
            $past(w_en5 && r_vl[4] && (r_pl[4].cmd == vfcm_pkg::CMD_SET_MASK)))
        else $error("presence mask changed without a set-mask item");

    a_out_dir_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(r_o.dir) < vfcm_pkg::NUM_DIRS))
        else $error("emitted face has an invalid direction");

    a_out_block_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_o.blk != 8'd0))
        else $error("emitted face belongs to an empty cell");

    a_face_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (!o_m_tvalid || (r_ok == 2'd0)))
        else $error("vertex count did not restart after the last vertex");

endmodule

/* sim/voxel_face_culling_mesher_tb.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_tb: self-checking bench for the face mesher
// Streams load, mask and examine commands and checks every vertex
// transaction against a behavioral mesher. It runs three idle mixes and
// holds off the output long enough to back up the input.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfcm_pkg::*;

    localparam int SIDE        = DEF_SIDE;
    localparam int CELLS       = SIDE * SIDE * SIDE;
    localparam int PLANE_SZ    = SIDE * SIDE;
    localparam logic [VAL_W-1:0] BLK_MASK = VAL_W'((1 << DEF_BLOCK_BITS) - 1);
    localparam int PHASE_ITEMS = 42;
    localparam int HOLD_CYC    = 120;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic [DIR_W-1:0] dir;
        logic [VAL_W-1:0] val;
        logic [MASK_W-1:0] msk;
    } mesh_cmd_t;

    typedef struct packed {
        logic                      last;
        logic [VAL_W-1:0]          blk;
        logic signed [NORM_W-1:0]  nz;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nx;
        logic [POS_W-1:0]          pz;
        logic [POS_W-1:0]          py;
        logic [POS_W-1:0]          px;
    } face_vertex_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tlast;

    mesh_cmd_t    cmd_q[$];
    face_vertex_t vertex_q[$];

    logic [VAL_W-1:0]  mesh_cells  [CELLS]             = '{default: '0};
    logic [VAL_W-1:0]  mesh_planes [NUM_DIRS*PLANE_SZ] = '{default: '0};
    logic [MASK_W-1:0] mesh_present = '0;

    bit cell_set  [CELLS]             = '{default: 1'b0};
    bit plane_set [NUM_DIRS*PLANE_SZ] = '{default: 1'b0};

    int send_idle_pct = 26;
    int recv_idle_pct = 68;
    int gen_cnt       = 0;
    int fail_cnt      = 0;
    int cycle_cnt     = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    bit s_taken       = 1'b0;

    voxel_face_culling_mesher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // entry across face dir: chunk cell index, or flat plane entry when on the boundary
    function automatic int beside_entry(int idx, int dir, output bit in_plane);
        int c[3];
        int axis;
        bit neg;
        c[0] = idx % SIDE;
        c[1] = (idx / SIDE) % SIDE;
        c[2] = idx / PLANE_SZ;
        axis = dir / 2;
        neg = (dir % 2) == 0;
        in_plane = neg ? (c[axis] == 0) : (c[axis] == SIDE - 1);
        if (in_plane) begin
            if (dir < 2) return dir * PLANE_SZ + c[1] + SIDE * c[2];
            if (dir < 4) return dir * PLANE_SZ + c[0] + SIDE * c[2];
            return dir * PLANE_SZ + c[0] + SIDE * c[1];
        end
        if (neg) c[axis]--; else c[axis]++;
        return c[0] + SIDE * (c[1] + SIDE * c[2]);
    endfunction

    function automatic void mesh_step(t_cmd cmd, logic [IDX_W-1:0] idx, logic [DIR_W-1:0] dir,
                                      logic [VAL_W-1:0] val, logic [MASK_W-1:0] msk);
        bit in_plane;
        int nb;
        int axis;
        logic [VAL_W-1:0] blk;
        logic [VAL_W-1:0] adj;
        logic [2:0] cr;
        logic signed [NORM_W-1:0] nv;
        face_vertex_t v;
        case (cmd)
            CMD_LOAD_CELL: begin
                if (idx < CELLS) mesh_cells[idx] = val & BLK_MASK;
            end
            CMD_LOAD_PLANE: begin
                if (dir < NUM_DIRS && idx < PLANE_SZ) mesh_planes[dir*PLANE_SZ+idx] = val & BLK_MASK;
            end
            CMD_SET_MASK: begin
                mesh_present = msk;
            end
            default: begin
                if (idx >= CELLS || dir >= NUM_DIRS) return;
                blk = mesh_cells[idx];
                if (blk == '0) return;
                nb = beside_entry(idx, dir, in_plane);
                if (in_plane && !mesh_present[dir]) return;
                adj = in_plane ? mesh_planes[nb] : mesh_cells[nb];
                if (adj != '0) return;
                axis = dir / 2;
                nv = dir[0] ? NORMAL_POS : NORMAL_NEG;
                for (int k = 0; k < 4; k++) begin
                    cr = CORNER_TAB[dir][k];
                    v.px = POS_W'(idx % SIDE + cr[0]);
                    v.py = POS_W'((idx / SIDE) % SIDE + cr[1]);
                    v.pz = POS_W'(idx / PLANE_SZ + cr[2]);
                    v.nx = (axis == 0) ? nv : NORMAL_ZERO;
                    v.ny = (axis == 1) ? nv : NORMAL_ZERO;
                    v.nz = (axis == 2) ? nv : NORMAL_ZERO;
                    v.blk = blk;
                    v.last = (k == 3);
                    vertex_q = {vertex_q, v};
                end
            end
        endcase
    endfunction

    task automatic push_item(t_cmd cmd, int idx, int dir, int val, int msk);
        mesh_cmd_t it;
        it.cmd = cmd;
        it.idx = IDX_W'(idx);
        it.dir = DIR_W'(dir);
        it.val = VAL_W'(val);
        it.msk = MASK_W'(msk);
        cmd_q = {cmd_q, it};
        if (cmd == CMD_LOAD_CELL) begin
            cell_set[it.idx] = 1'b1;
            gen_cnt++;
        end else if (cmd == CMD_LOAD_PLANE) begin
            if (it.dir < NUM_DIRS && it.idx < PLANE_SZ) begin
                plane_set[it.dir*PLANE_SZ+it.idx] = 1'b1;
                gen_cnt++;
            end
        end else if (cmd == CMD_SET_MASK || it.dir < NUM_DIRS) begin
            gen_cnt++;
        end
    endtask

    function automatic int rand_block();
        return $urandom_range(1) ? $urandom_range(255, 1) : 0;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return 0;
            1: return SIDE - 1;
            default: return $urandom_range(SIDE - 1);
        endcase
    endfunction

    // load whatever the examine will read; carve forces a solid cell and empty neighbor
    task automatic push_examine(int idx, int dir, bit carve);
        bit in_plane;
        int nb;
        nb = beside_entry(idx, dir, in_plane);
        if (carve || !cell_set[idx])
            push_item(CMD_LOAD_CELL, idx, $urandom_range(7),
                      carve ? $urandom_range(255, 1) : rand_block(), $urandom_range(63));
        if (in_plane) begin
            if (carve || !plane_set[nb])
                push_item(CMD_LOAD_PLANE, nb % PLANE_SZ, dir, carve ? 0 : rand_block(),
                          $urandom_range(63));
        end else if (carve || !cell_set[nb]) begin
            push_item(CMD_LOAD_CELL, nb, $urandom_range(7), carve ? 0 : rand_block(),
                      $urandom_range(63));
        end
        push_item(CMD_EXAMINE, idx, dir, $urandom_range(255), $urandom_range(63));
    endtask

    task automatic push_random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            push_item(CMD_SET_MASK, $urandom_range(CELLS - 1), $urandom_range(7),
                      $urandom_range(255), $urandom_range(1) ? 6'h3F : $urandom_range(63));
        end else if (pick < 14) begin
            case ($urandom_range(2))
                0: push_item(CMD_LOAD_PLANE, $urandom_range(CELLS - 1, PLANE_SZ),
                             $urandom_range(NUM_DIRS - 1), $urandom_range(255), 0);
                1: push_item(CMD_LOAD_PLANE, $urandom_range(PLANE_SZ - 1),
                             $urandom_range(7, NUM_DIRS), $urandom_range(255), 0);
                default: push_item(CMD_EXAMINE, $urandom_range(CELLS - 1),
                                   $urandom_range(7, NUM_DIRS), $urandom_range(255),
                                   $urandom_range(63));
            endcase
        end else if (pick < 34) begin
            push_item(CMD_LOAD_CELL, $urandom_range(CELLS - 1), $urandom_range(7),
                      rand_block(), $urandom_range(63));
        end else if (pick < 44) begin
            push_item(CMD_LOAD_PLANE, $urandom_range(PLANE_SZ - 1),
                      $urandom_range(NUM_DIRS - 1), rand_block(), $urandom_range(63));
        end else begin
            push_examine(rand_coord() + SIDE * (rand_coord() + SIDE * rand_coord()),
                         $urandom_range(NUM_DIRS - 1), $urandom_range(1));
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || i_s_tvalid || vertex_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            fail_cnt++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        mesh_cmd_t it;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = cmd_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {3'b000, it.msk, it.val, it.dir, it.idx};
                i_s_tuser  <= it.cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYC;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        face_vertex_t want;
        face_vertex_t got;
        if (o_m_tvalid && i_m_tready) begin
            got = {o_m_tlast, o_m_tdata[M_TDATA_W-2:0]};
            if (vertex_q.size() == 0) begin
                fail_cnt++;
                $display("%0t ns: expected no vertex, actual %h", $time, got);
            end else begin
                want = vertex_q.pop_front();
                check_field("pos_x", want.px, got.px);
                check_field("pos_y", want.py, got.py);
                check_field("pos_z", want.pz, got.pz);
                check_field("normal_x", want.nx, got.nx);
                check_field("normal_y", want.ny, got.ny);
                check_field("normal_z", want.nz, got.nz);
                check_field("vertex_block", want.blk, got.blk);
                check_field("last_vertex", want.last, got.last);
            end
        end
        s_taken <= i_s_tvalid && o_s_tready;
        if (i_s_tvalid && o_s_tready)
            mesh_step(t_cmd'(i_s_tuser), i_s_tdata[11:0], i_s_tdata[14:12],
                      i_s_tdata[22:15], i_s_tdata[28:23]);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        push_item(CMD_SET_MASK, 0, 0, 0, 6'h3F);
        push_item(CMD_LOAD_CELL, 0, 0, 8'hFF, 0);
        push_item(CMD_LOAD_PLANE, 0, 0, 0, 0);
        push_item(CMD_LOAD_PLANE, 0, 2, 8'h01, 0);
        push_item(CMD_LOAD_PLANE, 0, 4, 0, 0);
        push_item(CMD_LOAD_CELL, 1, 0, 0, 0);
        push_item(CMD_LOAD_CELL, SIDE, 0, 8'h55, 0);
        push_item(CMD_LOAD_CELL, PLANE_SZ, 0, 0, 0);
        for (int d = 0; d < NUM_DIRS; d++) push_examine(0, d, 1'b0);
        push_item(CMD_LOAD_CELL, CELLS - 1, 7, 8'h80, 6'h3F);
        push_item(CMD_LOAD_PLANE, PLANE_SZ - 1, 5, 0, 0);
        push_item(CMD_LOAD_PLANE, PLANE_SZ - 1, 1, 8'hFF, 0);
        push_examine(CELLS - 1, 5, 1'b0);
        push_examine(CELLS - 1, 1, 1'b0);
        push_item(CMD_LOAD_PLANE, CELLS - 1, 1, 0, 0);
        push_item(CMD_LOAD_PLANE, PLANE_SZ - 1, 7, 0, 0);
        push_examine(CELLS - 1, 1, 1'b0);
        push_item(CMD_SET_MASK, 0, 0, 0, 6'h1F);
        push_examine(CELLS - 1, 5, 1'b0);
        push_item(CMD_EXAMINE, 0, 6, 0, 0);
        push_item(CMD_EXAMINE, CELLS - 1, 7, 8'hFF, 6'h3F);
        push_examine(1, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        gen_cnt = 0;
        while (gen_cnt < PHASE_ITEMS) push_random_step();
        drain();

        send_idle_pct = 68;
        recv_idle_pct = 26;
        gen_cnt = 0;
        while (gen_cnt < PHASE_ITEMS) push_random_step();
        drain();

        // back up the pipeline with a burst of emitting examines
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_cnt = 0;
        push_item(CMD_SET_MASK, 0, 0, 0, 6'h3F);
        repeat (8) push_examine($urandom_range(CELLS - 1), $urandom_range(NUM_DIRS - 1), 1'b1);
        hold_req = 1'b1;
        while (gen_cnt < PHASE_ITEMS) push_random_step();
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && vertex_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
